/* design/scfd_pkg.sv */
// shared types and constants of the serial command framer/deframer
`default_nettype none

package scfd_pkg;

  // input item kinds
  localparam logic KIND_REQ = 1'b0;
  localparam logic KIND_RX  = 1'b1;

  // result kinds
  localparam logic [1:0] OUT_TX   = 2'd0;
  localparam logic [1:0] OUT_DATA = 2'd1;
  localparam logic [1:0] OUT_DONE = 2'd2;

  // completion status codes
  localparam logic [2:0] STS_OK       = 3'd0;
  localparam logic [2:0] STS_NAK      = 3'd1;
  localparam logic [2:0] STS_FORMAT   = 3'd2;
  localparam logic [2:0] STS_CHECKSUM = 3'd3;
  localparam logic [2:0] STS_SIZE     = 3'd4;

  // line characters and command codes
  localparam logic [7:0] CH_STX    = 8'h02;
  localparam logic [7:0] CH_ACK    = 8'h06;
  localparam logic [7:0] CMD_WRITE = 8'h81;
  localparam logic [7:0] CMD_READ  = 8'h80;

  // frame layout
  localparam logic [2:0] MAX_WR_BYTES = 3'd4;
  localparam logic [7:0] ID_BYTES     = 8'd3;

  // input item
  typedef struct packed {
    logic        kind;
    logic        is_write;
    logic [7:0]  class_id;
    logic [7:0]  instance_id;
    logic [7:0]  attribute_id;
    logic [31:0] write_word;
    logic [2:0]  write_count;
    logic [4:0]  expected_count;
    logic [7:0]  rx_byte;
  } req_t;

  // result item
  typedef struct packed {
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       retrying;
    logic       last;
  } rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic       load_req;
    logic       tx_start;
    logic       tx_next;
    logic       head_init;
    logic       head_step;
    logic       body_step;
    logic       data_start;
    logic       rd_issue;
    logic       data_next;
    logic       emit;
    logic [1:0] emit_kind;
    logic [2:0] emit_status;
    logic       emit_retrying;
    logic       emit_last;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic slot_free;
    logic is_ack;
    logic held_write;
    logic head_end;
    logic head_bad;
    logic body_check;
    logic frame_bad;
    logic sum_ok;
    logic len_short;
    logic size_bad;
    logic count_zero;
    logic tx_last;
    logic data_last;
  } dp_stat_t;

endpackage

`default_nettype wire

/* design/scfd_datapath.sv */
// datapath: held request, frame builder, reply parser, reply store and result register
`default_nettype none

module scfd_datapath #(
  parameter int MAX_REPLY = 16
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire [7:0]             dev_addr,
  input  wire scfd_pkg::req_t   in_data,
  input  wire scfd_pkg::dp_cmd_t cmd,
  output scfd_pkg::dp_stat_t    stat,
  output logic                  out_valid,
  input  wire                   out_ready,
  output scfd_pkg::rsp_t        out_data
);

  localparam int AW = (MAX_REPLY > 1) ? $clog2(MAX_REPLY) : 1;
  localparam int CW = $clog2(MAX_REPLY + 1);

  // held request
  logic [23:0] held_ids_r;
  logic [31:0] held_data_r;
  logic        held_wr_r;
  logic [2:0]  n_r;
  logic [4:0]  exp_r;

  // transmit side
  logic [3:0]  idx_r;
  logic [7:0]  txsum_r;

  // receive side
  logic [8:0]  pos_r;
  logic [7:0]  len_r;
  logic [7:0]  rxsum_r;
  logic        bad_r;

  // reply store and readout
  logic [7:0]    mem [MAX_REPLY];
  logic [CW-1:0] didx_r;
  logic [7:0]    rd_data_r;

  // result register
  logic           out_valid_r;
  scfd_pkg::rsp_t out_r;

  logic [7:0] rx_b;
  logic [7:0] fb;
  logic [2:0] n_load;
  logic [3:0] data_end;
  logic       head_bad;
  logic       body_in;
  logic       body_pad;
  logic [8:0] wa;
  logic       wr_en;
  logic [7:0] cnt8;
  logic [1:0] dsel;

  assign rx_b = in_data.rx_byte;

  // data byte count of a new request
  always_comb begin
    if (!in_data.is_write) begin
      n_load = 3'd0;
    end else if (in_data.write_count > scfd_pkg::MAX_WR_BYTES) begin
      n_load = scfd_pkg::MAX_WR_BYTES;
    end else begin
      n_load = in_data.write_count;
    end
  end

  // frame byte at the current position
  assign data_end = 4'd7 + {1'b0, n_r};
  assign dsel     = 2'(idx_r - 4'd7);
  always_comb begin
    fb = txsum_r;
    unique case (idx_r)
      4'd0: fb = dev_addr;
      4'd1: fb = scfd_pkg::CH_STX;
      4'd2: fb = held_wr_r ? scfd_pkg::CMD_WRITE : scfd_pkg::CMD_READ;
      4'd3: fb = scfd_pkg::ID_BYTES + {5'd0, n_r};
      4'd4: fb = held_ids_r[23:16];
      4'd5: fb = held_ids_r[15:8];
      4'd6: fb = held_ids_r[7:0];
      default: begin
        if (idx_r < data_end) begin
          unique case (dsel)
            2'd0: fb = held_data_r[7:0];
            2'd1: fb = held_data_r[15:8];
            2'd2: fb = held_data_r[23:16];
            2'd3: fb = held_data_r[31:24];
          endcase
        end else if (idx_r == data_end) begin
          fb = 8'd0;
        end else begin
          fb = txsum_r;
        end
      end
    endcase
  end

  // receive checks
  assign head_bad = bad_r || (pos_r == 9'd0 && rx_b != 8'd0) ||
                    (pos_r == 9'd1 && rx_b != scfd_pkg::CH_STX);
  assign body_in  = pos_r < {1'b0, len_r};
  assign body_pad = pos_r == {1'b0, len_r};
  assign wa       = pos_r - 9'd3;
  assign wr_en    = cmd.body_step && body_in && pos_r >= 9'd3 && wa < 9'(MAX_REPLY);
  assign cnt8     = len_r - scfd_pkg::ID_BYTES;

  // status toward the controller
  always_comb begin
    stat.slot_free  = !out_valid_r || out_ready;
    stat.is_ack     = rx_b == scfd_pkg::CH_ACK;
    stat.held_write = held_wr_r;
    stat.head_end   = pos_r >= 9'd3;
    stat.head_bad   = head_bad;
    stat.body_check = !body_in && !body_pad;
    stat.frame_bad  = bad_r;
    stat.sum_ok     = rxsum_r == rx_b;
    stat.len_short  = len_r < scfd_pkg::ID_BYTES;
    stat.size_bad   = ({1'b0, cnt8} > 9'(MAX_REPLY)) ||
                      (exp_r != 5'd0 && {3'd0, exp_r} != cnt8);
    stat.count_zero = cnt8 == 8'd0;
    stat.tx_last    = idx_r == data_end + 4'd1;
    stat.data_last  = (didx_r + CW'(1)) == cnt8[CW-1:0];
  end

  // held request and transmit sequencing
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      held_ids_r  <= {in_data.class_id, in_data.instance_id, in_data.attribute_id};
      held_data_r <= in_data.write_word;
      held_wr_r   <= in_data.is_write;
      n_r         <= n_load;
      exp_r       <= in_data.expected_count;
    end
    if (cmd.tx_start) begin
      idx_r   <= 4'd0;
      txsum_r <= 8'd0;
    end else if (cmd.tx_next) begin
      idx_r <= idx_r + 4'd1;
      if (idx_r != 4'd0) begin
        txsum_r <= txsum_r + fb;
      end
    end
  end

  // reply parsing
  always_ff @(posedge clk) begin
    if (cmd.head_init) begin
      pos_r   <= 9'd0;
      rxsum_r <= 8'd0;
      bad_r   <= 1'b0;
    end else if (cmd.head_step) begin
      rxsum_r <= rxsum_r + rx_b;
      bad_r   <= head_bad;
      if (pos_r >= 9'd3) begin
        len_r <= rx_b;
        pos_r <= 9'd0;
      end else begin
        pos_r <= pos_r + 9'd1;
      end
    end else if (cmd.body_step) begin
      if (body_in) begin
        rxsum_r <= rxsum_r + rx_b;
        pos_r   <= pos_r + 9'd1;
      end else if (body_pad) begin
        rxsum_r <= rxsum_r + rx_b;
        bad_r   <= bad_r || (rx_b != 8'd0);
        pos_r   <= pos_r + 9'd1;
      end
    end
  end

  // reply store write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wa[AW-1:0]] <= rx_b;
    end
  end

  // reply store readout
  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_data_r <= mem[didx_r[AW-1:0]];
    end
    if (cmd.data_start) begin
      didx_r <= '0;
    end else if (cmd.data_next) begin
      didx_r <= didx_r + CW'(1);
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.out_kind <= cmd.emit_kind;
      unique case (cmd.emit_kind)
        scfd_pkg::OUT_TX:   out_r.out_byte <= fb;
        scfd_pkg::OUT_DATA: out_r.out_byte <= rd_data_r;
        default:            out_r.out_byte <= 8'd0;
      endcase
      out_r.status   <= cmd.emit_status;
      out_r.retrying <= cmd.emit_retrying;
      out_r.last     <= cmd.emit_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

/* design/scfd_ctrl.sv */
// controller: protocol phase, retry budget and result sequencing
`default_nettype none

module scfd_ctrl #(
  parameter int RETRIES = 1
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  input  wire                    in_kind,
  output logic                   in_ready,
  input  wire scfd_pkg::dp_stat_t stat,
  output scfd_pkg::dp_cmd_t      cmd
);

  localparam int RW = (RETRIES > 0) ? $clog2(RETRIES + 1) : 1;

  // sequencer states
  localparam logic [2:0] ST_WAIT = 3'd0;
  localparam logic [2:0] ST_TX   = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_DATA = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  // protocol phases
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_ACK1 = 3'd1;
  localparam logic [2:0] PH_ACK2 = 3'd2;
  localparam logic [2:0] PH_HEAD = 3'd3;
  localparam logic [2:0] PH_BODY = 3'd4;

  logic [2:0]    st_r, st_nxt;
  logic [2:0]    ph_r, ph_nxt;
  logic [RW-1:0] retry_r, retry_nxt;
  logic          rtx_r, rtx_nxt;
  logic [2:0]    status_r, status_nxt;

  logic       do_fail;
  logic       do_fin;
  logic [2:0] fail_code;
  logic [2:0] fin_code;

  assign in_ready = st_r == ST_WAIT;

  // next state and commands
  always_comb begin
    st_nxt     = st_r;
    ph_nxt     = ph_r;
    retry_nxt  = retry_r;
    rtx_nxt    = rtx_r;
    status_nxt = status_r;
    cmd        = '0;
    do_fail    = 1'b0;
    do_fin     = 1'b0;
    fail_code  = scfd_pkg::STS_OK;
    fin_code   = scfd_pkg::STS_OK;

    unique case (st_r)
      ST_WAIT: begin
        if (in_valid) begin
          if (in_kind == scfd_pkg::KIND_REQ) begin
            // new request: fresh retry budget, send the frame
            cmd.load_req = 1'b1;
            cmd.tx_start = 1'b1;
            retry_nxt    = '0;
            rtx_nxt      = 1'b0;
            st_nxt       = ST_TX;
            ph_nxt       = PH_ACK1;
          end else begin
            unique case (ph_r)
              PH_ACK1: begin
                if (!stat.is_ack) begin
                  do_fail   = 1'b1;
                  fail_code = scfd_pkg::STS_NAK;
                end else if (stat.held_write) begin
                  ph_nxt = PH_ACK2;
                end else begin
                  ph_nxt        = PH_HEAD;
                  cmd.head_init = 1'b1;
                end
              end
              PH_ACK2: begin
                if (!stat.is_ack) begin
                  do_fail   = 1'b1;
                  fail_code = scfd_pkg::STS_NAK;
                end else begin
                  do_fin   = 1'b1;
                  fin_code = scfd_pkg::STS_OK;
                end
              end
              PH_HEAD: begin
                cmd.head_step = 1'b1;
                if (stat.head_end) begin
                  if (stat.head_bad) begin
                    do_fail   = 1'b1;
                    fail_code = scfd_pkg::STS_FORMAT;
                  end else begin
                    ph_nxt = PH_BODY;
                  end
                end
              end
              PH_BODY: begin
                cmd.body_step = 1'b1;
                if (stat.body_check) begin
                  priority if (stat.frame_bad) begin
                    do_fail   = 1'b1;
                    fail_code = scfd_pkg::STS_FORMAT;
                  end else if (!stat.sum_ok) begin
                    do_fail   = 1'b1;
                    fail_code = scfd_pkg::STS_CHECKSUM;
                  end else if (stat.len_short) begin
                    do_fail   = 1'b1;
                    fail_code = scfd_pkg::STS_FORMAT;
                  end else if (stat.size_bad) begin
                    do_fin   = 1'b1;
                    fin_code = scfd_pkg::STS_SIZE;
                  end else begin
                    // good reply: stream the data bytes out, then complete
                    ph_nxt         = PH_IDLE;
                    status_nxt     = scfd_pkg::STS_OK;
                    cmd.data_start = 1'b1;
                    st_nxt         = stat.count_zero ? ST_DONE : ST_RD;
                  end
                end
              end
              default: begin
                // byte while idle is dropped
              end
            endcase
          end
        end
      end
      ST_TX: begin
        if (stat.slot_free) begin
          cmd.emit          = 1'b1;
          cmd.emit_kind     = scfd_pkg::OUT_TX;
          cmd.emit_retrying = rtx_r;
          cmd.emit_last     = stat.tx_last;
          cmd.tx_next       = 1'b1;
          if (stat.tx_last) begin
            st_nxt = ST_WAIT;
          end
        end
      end
      ST_RD: begin
        cmd.rd_issue = 1'b1;
        st_nxt       = ST_DATA;
      end
      ST_DATA: begin
        if (stat.slot_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = scfd_pkg::OUT_DATA;
          cmd.data_next = 1'b1;
          st_nxt        = stat.data_last ? ST_DONE : ST_RD;
        end
      end
      ST_DONE: begin
        if (stat.slot_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_kind   = scfd_pkg::OUT_DONE;
          cmd.emit_status = status_r;
          cmd.emit_last   = 1'b1;
          st_nxt          = ST_WAIT;
        end
      end
      default: begin
        st_nxt = ST_WAIT;
      end
    endcase

    // protocol error: resend while budget lasts, else complete with the error
    if (do_fail) begin
      if (retry_r < RW'(RETRIES)) begin
        retry_nxt    = retry_r + RW'(1);
        rtx_nxt      = 1'b1;
        cmd.tx_start = 1'b1;
        st_nxt       = ST_TX;
        ph_nxt       = PH_ACK1;
      end else begin
        do_fin   = 1'b1;
        fin_code = fail_code;
      end
    end

    // exchange finished: one completion result
    if (do_fin) begin
      ph_nxt     = PH_IDLE;
      status_nxt = fin_code;
      st_nxt     = ST_DONE;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_WAIT;
      ph_r     <= PH_IDLE;
      retry_r  <= '0;
      rtx_r    <= 1'b0;
      status_r <= scfd_pkg::STS_OK;
    end else begin
      st_r     <= st_nxt;
      ph_r     <= ph_nxt;
      retry_r  <= retry_nxt;
      rtx_r    <= rtx_nxt;
      status_r <= status_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/serial_command_framer_deframer_top.sv */
// top level of the serial command framer/deframer: address register, controller, datapath
//
// Usage: an input item is either a request (kind 0) or one byte received from
// the line (kind 1). A request produces the transmit frame on the result
// channel, one byte per result (9 to 13 results), the last one flagged.
// Received bytes are parsed against the pending exchange; most produce no
// result. The byte that ends an exchange produces the response data bytes
// (reads only) and one completion with a status, or a retransmitted frame
// after the first protocol error. The user must write the device address through the cfg
// channel while the block is idle; the block does not enforce it. cfg_ready is always high.
// Flow: the block works on one item at a time. A request is accepted, then
// its frame bytes are output in order. A completing read byte is followed by
// a reply store read and then an output for each data byte, then by the
// completion. A byte with no result leaves the input open. A single output
// register parts the channels; a stalled receiver holds the sequencer until
// that register frees up. Reset clears the address, the protocol phase and
// the output register; no reply store clearing is needed.
`default_nettype none

module serial_command_framer_deframer_top #(
  parameter int MAX_REPLY = 16,
  parameter int RETRIES   = 1
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire scfd_pkg::req_t in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output scfd_pkg::rsp_t      out_data,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire [7:0]           cfg_data
);

  logic [7:0]        dev_addr_r;
  scfd_pkg::dp_cmd_t cmd;
  scfd_pkg::dp_stat_t stat;

  // device address register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= 8'd0;
    end else if (cfg_valid) begin
      dev_addr_r <= cfg_data;
    end
  end

  // controller
  scfd_ctrl #(
    .RETRIES (RETRIES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  scfd_datapath #(
    .MAX_REPLY (MAX_REPLY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .dev_addr  (dev_addr_r),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // a request keeps the input closed while its frame goes out
  a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.kind == scfd_pkg::KIND_REQ |=> !in_ready)
    else $error("input open right after a request");

  // only completions carry a status
  a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_kind != scfd_pkg::OUT_DONE |-> out_data.status == scfd_pkg::STS_OK)
    else $error("status on a non-completion result");

  // only transmit bytes are marked as retry
  a_retry_tx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.retrying |-> out_data.out_kind == scfd_pkg::OUT_TX)
    else $error("retry flag on a non-transmit result");

  // a completion always ends its item's results
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_kind == scfd_pkg::OUT_DONE |-> out_data.last)
    else $error("completion without last");

endmodule

`default_nettype wire

/* sim/serial_command_framer_deframer_top_test.sv */
// testbench for the serial command framer/deframer: directed and random exchanges with a scoreboard
module serial_command_framer_deframer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPLY_DEPTH  = 16;
  localparam int RETRY_LIMIT  = 1;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_DELAY = 4;
  localparam int TAIL_CYCLES  = 20;

  // protocol phase of the pending exchange
  typedef enum logic [2:0] {
    LINK_IDLE, LINK_ACK1, LINK_ACK2, LINK_HEAD, LINK_BODY
  } link_state_t;

  // ways a device answer can go wrong
  typedef enum int {
    FAULT_NONE, FAULT_NAK, FAULT_NAK2, FAULT_HEAD0, FAULT_HEAD1,
    FAULT_PAD, FAULT_SUM, FAULT_SHORT, FAULT_CUT
  } fault_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  scfd_pkg::req_t  in_data = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  scfd_pkg::rsp_t  out_data;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [7:0]      cfg_data = 8'h00;

  // testbench control
  bit          idle_on = 1'b1;
  int          hold_cycles = 0;
  int          items_done = 0;
  int          errors = 0;
  int unsigned cycle_count = 0;

  // exchange tracking state
  scfd_pkg::rsp_t due_results[$];
  link_state_t    link_state = LINK_IDLE;
  logic [7:0]     addr_reg = 8'h00;
  logic [23:0]    cur_ids = '0;
  logic [31:0]    cur_word = '0;
  logic           cur_write = 1'b0;
  logic [2:0]     cur_wcount = '0;
  logic [4:0]     cur_expect = '0;
  int             rx_pos = 0;
  int             rx_len = 0;
  logic [7:0]     rx_sum = 8'h00;
  int             retry_used = 0;
  logic           rx_bad = 1'b0;
  logic [7:0]     reply_bytes [REPLY_DEPTH];

  serial_command_framer_deframer_top #(
    .MAX_REPLY(REPLY_DEPTH),
    .RETRIES(RETRY_LIMIT)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("serial_command_framer_deframer_top_test: done, errors");
      $finish;
    end
  end

  // expected result bookkeeping
  function automatic void push_out(logic [1:0] kind, logic [7:0] value, logic [2:0] sts,
                                   logic retry);
    scfd_pkg::rsp_t r;
    r.out_kind = kind;
    r.out_byte = value;
    r.status   = sts;
    r.retrying = retry;
    r.last     = 1'b0;
    due_results = {due_results, r};
  endfunction

  // transmit frame for the held request
  function automatic void emit_frame(logic retry);
    logic [7:0] bytes[$];
    logic [7:0] sum;
    logic [2:0] nbytes;
    int i;
    nbytes = !cur_write ? 3'd0 :
             (cur_wcount > scfd_pkg::MAX_WR_BYTES) ? scfd_pkg::MAX_WR_BYTES : cur_wcount;
    bytes = {bytes, scfd_pkg::CH_STX};
    bytes = {bytes, cur_write ? scfd_pkg::CMD_WRITE : scfd_pkg::CMD_READ};
    bytes = {bytes, 8'(scfd_pkg::ID_BYTES + 8'(nbytes))};
    bytes = {bytes, cur_ids[23:16]};
    bytes = {bytes, cur_ids[15:8]};
    bytes = {bytes, cur_ids[7:0]};
    for (i = 0; i < int'(nbytes); i++) bytes = {bytes, cur_word[8*i +: 8]};
    bytes = {bytes, 8'h00};
    sum = 8'h00;
    push_out(scfd_pkg::OUT_TX, addr_reg, scfd_pkg::STS_OK, retry);
    foreach (bytes[j]) begin
      sum += bytes[j];
      push_out(scfd_pkg::OUT_TX, bytes[j], scfd_pkg::STS_OK, retry);
    end
    push_out(scfd_pkg::OUT_TX, sum, scfd_pkg::STS_OK, retry);
    link_state = LINK_ACK1;
  endfunction

  function automatic void end_exchange(logic [2:0] sts);
    link_state = LINK_IDLE;
    push_out(scfd_pkg::OUT_DONE, 8'h00, sts, 1'b0);
  endfunction

  // first protocol error resends the frame, later ones complete
  function automatic void protocol_error(logic [2:0] sts);
    if (retry_used < RETRY_LIMIT) begin
      retry_used++;
      emit_frame(1'b1);
    end else begin
      end_exchange(sts);
    end
  endfunction

  // reply body, then pad, then checksum
  function automatic void absorb_body_byte(logic [7:0] b);
    int count;
    if (rx_pos < rx_len) begin
      rx_sum += b;
      if (rx_pos >= 3 && rx_pos - 3 < REPLY_DEPTH) reply_bytes[rx_pos - 3] = b;
      rx_pos++;
    end else if (rx_pos == rx_len) begin
      if (b != 8'h00) rx_bad = 1'b1;
      rx_sum += b;
      rx_pos++;
    end else if (rx_bad) begin
      protocol_error(scfd_pkg::STS_FORMAT);
    end else if (rx_sum != b) begin
      protocol_error(scfd_pkg::STS_CHECKSUM);
    end else if (rx_len < int'(scfd_pkg::ID_BYTES)) begin
      protocol_error(scfd_pkg::STS_FORMAT);
    end else begin
      count = rx_len - int'(scfd_pkg::ID_BYTES);
      if (count > REPLY_DEPTH || (cur_expect != 0 && int'(cur_expect) != count)) begin
        end_exchange(scfd_pkg::STS_SIZE);
      end else begin
        for (int i = 0; i < count; i++) begin
          push_out(scfd_pkg::OUT_DATA, reply_bytes[i], scfd_pkg::STS_OK, 1'b0);
        end
        end_exchange(scfd_pkg::STS_OK);
      end
    end
  endfunction

  // advance the exchange by one accepted item
  function automatic void step_exchange(scfd_pkg::req_t item);
    int queued;
    scfd_pkg::rsp_t tail;
    queued = due_results.size();
    if (item.kind == scfd_pkg::KIND_REQ) begin
      cur_ids    = {item.class_id, item.instance_id, item.attribute_id};
      cur_word   = item.write_word;
      cur_write  = item.is_write;
      cur_wcount = item.write_count;
      cur_expect = item.expected_count;
      retry_used = 0;
      emit_frame(1'b0);
    end else begin
      case (link_state)
        LINK_ACK1: begin
          if (item.rx_byte != scfd_pkg::CH_ACK) begin
            protocol_error(scfd_pkg::STS_NAK);
          end else if (cur_write) begin
            link_state = LINK_ACK2;
          end else begin
            link_state = LINK_HEAD;
            rx_pos = 0;
            rx_sum = 8'h00;
            rx_bad = 1'b0;
          end
        end
        LINK_ACK2: begin
          if (item.rx_byte != scfd_pkg::CH_ACK) protocol_error(scfd_pkg::STS_NAK);
          else end_exchange(scfd_pkg::STS_OK);
        end
        LINK_HEAD: begin
          rx_sum += item.rx_byte;
          if ((rx_pos == 0 && item.rx_byte != 8'h00) ||
              (rx_pos == 1 && item.rx_byte != scfd_pkg::CH_STX))
            rx_bad = 1'b1;
          if (rx_pos >= 3) begin
            rx_len = int'(item.rx_byte);
            if (rx_bad) begin
              protocol_error(scfd_pkg::STS_FORMAT);
            end else begin
              link_state = LINK_BODY;
              rx_pos = 0;
            end
          end else begin
            rx_pos++;
          end
        end
        LINK_BODY: absorb_body_byte(item.rx_byte);
        default: ;
      endcase
    end
    // flag the final result of this item
    if (due_results.size() > queued) begin
      tail = due_results.pop_back();
      tail.last = 1'b1;
      due_results = {due_results, tail};
    end
  endfunction

  // result checker
  always @(posedge clk) begin : result_check
    scfd_pkg::rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $error("unexpected result: out_kind %0d out_byte 0x%02h status %0d",
               out_data.out_kind, out_data.out_byte, out_data.status);
        errors++;
      end else begin
        want = due_results.pop_front();
        if (out_data.out_kind !== want.out_kind) begin
          $error("out_kind: expected %0d, got %0d", want.out_kind, out_data.out_kind);
          errors++;
        end
        if (out_data.out_byte !== want.out_byte) begin
          $error("out_byte: expected 0x%02h, got 0x%02h", want.out_byte, out_data.out_byte);
          errors++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          errors++;
        end
        if (out_data.retrying !== want.retrying) begin
          $error("retrying: expected %0d, got %0d", want.retrying, out_data.retrying);
          errors++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_data.last);
          errors++;
        end
      end
    end
  end

  // receiver: ready spans, random stalls, and an occasional long hold-off
  initial begin : receiver
    int span;
    forever begin
      if (hold_cycles != 0) begin
        span = hold_cycles;
        hold_cycles = 0;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        span = $urandom_range(1, 7);
        out_ready <= 1'b0;
      end else begin
        span = $urandom_range(1, 12);
        out_ready <= 1'b1;
      end
      repeat (span) @(posedge clk);
    end
  end

  // item builders
  function automatic scfd_pkg::req_t noise_fields();
    scfd_pkg::req_t r;
    r.kind           = 1'($urandom);
    r.is_write       = 1'($urandom);
    r.class_id       = 8'($urandom);
    r.instance_id    = 8'($urandom);
    r.attribute_id   = 8'($urandom);
    r.write_word     = $urandom;
    r.write_count    = 3'($urandom);
    r.expected_count = 5'($urandom);
    r.rx_byte        = 8'($urandom);
    return r;
  endfunction

  function automatic scfd_pkg::req_t make_request(logic wr, logic [2:0] wcount,
                                                  logic [4:0] want_n);
    scfd_pkg::req_t r;
    r = noise_fields();
    r.kind           = scfd_pkg::KIND_REQ;
    r.is_write       = wr;
    r.write_count    = wcount;
    r.expected_count = want_n;
    return r;
  endfunction

  function automatic logic [7:0] not_ack();
    logic [7:0] b;
    b = 8'($urandom);
    return (b == scfd_pkg::CH_ACK) ? ~b : b;
  endfunction

  function automatic logic [7:0] not_stx();
    logic [7:0] b;
    b = 8'($urandom);
    return (b == scfd_pkg::CH_STX) ? ~b : b;
  endfunction

  // send one item, with an optional gap in front
  task automatic send_item(input scfd_pkg::req_t item);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    if (!(item.kind == scfd_pkg::KIND_RX && link_state == LINK_IDLE)) items_done++;
    step_exchange(item);
  endtask

  task automatic send_rx(input logic [7:0] b);
    scfd_pkg::req_t r;
    r = noise_fields();
    r.kind    = scfd_pkg::KIND_RX;
    r.rx_byte = b;
    send_item(r);
  endtask

  // wait until every expected result has arrived
  task automatic drain_results();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_DELAY) @(posedge clk);
  endtask

  // close any open exchange, then let the block go quiet
  task automatic quiesce();
    if (link_state != LINK_IDLE) begin
      send_item(make_request(1'b1, 3'($urandom), 5'($urandom)));
      send_rx(scfd_pkg::CH_ACK);
      send_rx(scfd_pkg::CH_ACK);
    end
    drain_results();
  endtask

  task automatic write_address(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    addr_reg = value;
  endtask

  // device answers
  task automatic answer_write(input fault_t fault);
    case (fault)
      FAULT_NAK: send_rx(not_ack());
      FAULT_NAK2: begin
        send_rx(scfd_pkg::CH_ACK);
        send_rx(not_ack());
      end
      FAULT_CUT: send_rx(scfd_pkg::CH_ACK);
      default: begin
        send_rx(scfd_pkg::CH_ACK);
        send_rx(scfd_pkg::CH_ACK);
      end
    endcase
  endtask

  task automatic answer_read(input fault_t fault, input int ndata);
    logic [7:0] head [4];
    logic [7:0] sum;
    logic [7:0] len;
    logic [7:0] b;
    int i;
    if (fault == FAULT_NAK) begin
      send_rx(not_ack());
      return;
    end
    send_rx(scfd_pkg::CH_ACK);
    len = (fault == FAULT_SHORT) ? 8'($urandom_range(0, 2)) : 8'(ndata + 3);
    head[0] = (fault == FAULT_HEAD0) ? 8'($urandom_range(1, 255)) : 8'h00;
    head[1] = (fault == FAULT_HEAD1) ? not_stx() : scfd_pkg::CH_STX;
    head[2] = 8'($urandom);
    head[3] = len;
    sum = 8'h00;
    for (i = 0; i < 4; i++) begin
      sum += head[i];
      send_rx(head[i]);
    end
    if (fault == FAULT_HEAD0 || fault == FAULT_HEAD1) return;
    for (i = 0; i < int'(len); i++) begin
      if (fault == FAULT_CUT && i == int'(len) / 2) return;
      b = 8'($urandom);
      sum += b;
      send_rx(b);
    end
    b = (fault == FAULT_PAD) ? 8'($urandom_range(1, 255)) : 8'h00;
    sum += b;
    send_rx(b);
    send_rx((fault == FAULT_SUM) ? (sum ^ 8'($urandom_range(1, 255))) : sum);
  endtask

  function automatic fault_t pick_fault(logic wr);
    if ($urandom_range(0, 1) == 0) return FAULT_NONE;
    if (wr) begin
      case ($urandom_range(0, 2))
        0: return FAULT_NAK;
        1: return FAULT_NAK2;
        default: return FAULT_CUT;
      endcase
    end
    case ($urandom_range(0, 6))
      0: return FAULT_NAK;
      1: return FAULT_HEAD0;
      2: return FAULT_HEAD1;
      3: return FAULT_PAD;
      4: return FAULT_SUM;
      5: return FAULT_SHORT;
      default: return FAULT_CUT;
    endcase
  endfunction

  // one request and the device's answers, including the retry
  task automatic run_exchange();
    logic       wr;
    logic [2:0] wcount;
    logic [4:0] want_n;
    int         ndata;
    int         sel;
    int         tries;
    fault_t     fault;
    wr = 1'($urandom);
    wcount = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    sel = $urandom_range(0, 7);
    if (sel < 6) ndata = $urandom_range(0, 4);
    else if (sel == 6) ndata = $urandom_range(5, 16);
    else ndata = $urandom_range(17, 20);
    case ($urandom_range(0, 3))
      0: want_n = 5'd0;
      1, 2: want_n = 5'(ndata);
      default: want_n = 5'($urandom);
    endcase
    send_item(make_request(wr, wcount, want_n));
    tries = 0;
    do begin
      fault = pick_fault(wr);
      if (wr) answer_write(fault);
      else answer_read(fault, ndata);
      tries++;
    end while (fault != FAULT_CUT && link_state == LINK_ACK1 && tries < 3);
  endtask

  // frame layout at the field extremes, plus complete exchanges
  task automatic test_frame_layout();
    scfd_pkg::req_t r;
    r = make_request(1'b1, 3'd4, 5'd0);
    r.class_id     = 8'hFF;
    r.instance_id  = 8'hFF;
    r.attribute_id = 8'hFF;
    r.write_word   = 32'hFFFF_FFFF;
    send_item(r);
    send_rx(scfd_pkg::CH_ACK);
    send_rx(scfd_pkg::CH_ACK);
    // write count above four, all-zero ids and data
    r = make_request(1'b1, 3'd7, 5'd31);
    r.class_id     = 8'h00;
    r.instance_id  = 8'h00;
    r.attribute_id = 8'h00;
    r.write_word   = 32'h0000_0000;
    send_item(r);
    send_rx(scfd_pkg::CH_ACK);
    send_rx(scfd_pkg::CH_ACK);
    // read with an empty reply
    send_item(make_request(1'b0, 3'($urandom), 5'd0));
    answer_read(FAULT_NONE, 0);
  endtask

  // idle byte, abandoned request, not acknowledged twice
  task automatic test_special_cases();
    send_rx(scfd_pkg::CH_ACK);
    send_item(make_request(1'b1, 3'd2, 5'd0));
    send_item(make_request(1'b0, 3'd0, 5'd16));
    send_rx(not_ack());
    send_rx(not_ack());
  endtask

  // receiver holds off while requests keep coming
  task automatic test_backpressure();
    hold_cycles = 300;
    repeat (5) send_item(make_request(1'($urandom), 3'($urandom), 5'($urandom)));
    drain_results();
  endtask

  task automatic test_random_exchanges(input int quota);
    int start;
    start = items_done;
    while (items_done - start < quota) begin
      if (link_state == LINK_IDLE && $urandom_range(0, 9) == 0) send_rx(8'($urandom));
      run_exchange();
      if ($urandom_range(0, 7) == 0) drain_results();
    end
  endtask

  task automatic test_full_rate(input int quota);
    idle_on = 1'b0;
    test_random_exchanges(quota);
  endtask

  // test sequence
  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_frame_layout();
    test_special_cases();
    quiesce();
    write_address(8'hFF);
    test_backpressure();
    quiesce();
    write_address(8'h00);
    test_random_exchanges(55);
    quiesce();
    write_address(8'($urandom));
    test_random_exchanges(55);
    quiesce();
    write_address(8'h5A);
    test_full_rate(20);
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("serial_command_framer_deframer_top_test: done, clean");
    end else begin
      $display("serial_command_framer_deframer_top_test: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
design/scfd_pkg.sv
design/scfd_datapath.sv
design/scfd_ctrl.sv
design/serial_command_framer_deframer_top.sv
sim/serial_command_framer_deframer_top_test.sv
